[rtl/lcdni_pkg.sv]
package lcdni_pkg;

    localparam int CLK_PER_US = 50;
    localparam int PRESC_W    = $clog2(CLK_PER_US);

    localparam int STROBE_W = 10;
    localparam logic [STROBE_W-1:0] STROBE_RESET = 10'd20;
    localparam int US_W = STROBE_W + 1;

    localparam int IDX_W = 5;
    localparam logic [IDX_W-1:0] INIT_LAST_IDX = 5'd25;
    localparam logic [IDX_W-1:0] BYTE_LAST_IDX = 5'd1;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    typedef logic [2:0] op_t;
    localparam op_t OP_DATA    = 3'd0;
    localparam op_t OP_CMD     = 3'd1;
    localparam op_t OP_CURSOR  = 3'd2;
    localparam op_t OP_CLEAR   = 3'd3;
    localparam op_t OP_HOME    = 3'd4;
    localparam op_t OP_DISPLAY = 3'd5;
    localparam op_t OP_INIT    = 3'd6;

    localparam logic [7:0] CMD_ROW0    = 8'h80;
    localparam logic [7:0] CMD_ROW1    = 8'hC0;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [7:0] CMD_DISPLAY = 8'h08;

    localparam logic [5:0] PAUSE_POWER_UP_MS = 6'd50;
    localparam logic [2:0] PAUSE_FIRST_MS    = 3'd5;
    localparam logic [2:0] PAUSE_INIT_MS     = 3'd1;
    localparam logic [2:0] PAUSE_SLOW_MS     = 3'd2;

    typedef struct packed {
        logic load;
        logic start;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_known;
        logic timer_done;
        logic out_free;
        logic nib_last;
    } dp_sts_t;

    function automatic logic [7:0] init_cmd(input logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd0, 4'd1, 4'd2: c = 8'h30;
            4'd3, 4'd4:       c = 8'h20;
            4'd5:             c = 8'h28;
            4'd7:             c = 8'h08;
            4'd9:             c = 8'h01;
            4'd11:            c = 8'h06;
            4'd12:            c = 8'h0C;
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/char_lcd_nibble_interface.sv]
// Character LCD controller for a 4-bit bus. One input transaction is a request (tuser: operation;
// tdata: byte, row, column, display/cursor/blink bits) and yields a run of nibble transactions,
// high nibble first, tlast on the final one; init yields 26, every other operation 2, and
// operation 7 is accepted and yields none. The pauses in each nibble are reported in
// milliseconds for the pin driver to honour. Each nibble is issued once the strobe counter, counting
// microseconds at a 50 MHz clock, reaches twice strobe_us after the previous nibble (or after
// acceptance) and the output register is free, so a low m_tready holds it back. The next request
// can be taken in the cycle after the last nibble of a run is emitted.
module char_lcd_nibble_interface (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lcdni_pkg::STROBE_W-1:0]  cfg_wdata,   // strobe_us
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // byte_value[7:0], row[9:8], column[15:10], display_on[16], cursor_on[17], blink_on[18]
    input  logic [lcdni_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [2:0]                      s_tuser,     // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // nibble[3:0], pause_before_ms[9:4], pause_after_ms[12:10]
    output logic [lcdni_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser,     // register_select
    output logic                            m_tlast      // last_of_run
);

    lcdni_pkg::ctrl_cmd_t cmd;
    lcdni_pkg::dp_sts_t   sts;

    lcdni_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcdni_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[rtl/lcdni_datapath.sv]
module lcdni_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lcdni_pkg::STROBE_W-1:0]   cfg_wdata,
    input  logic [lcdni_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [2:0]                       s_tuser,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [lcdni_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast,
    input  lcdni_pkg::ctrl_cmd_t             cmd,
    output lcdni_pkg::dp_sts_t               sts
);

    logic [lcdni_pkg::STROBE_W-1:0] strobe_reg;
    lcdni_pkg::op_t                 op_reg;
    logic [7:0]                     bv_reg;
    logic [1:0]                     row_reg;
    logic [5:0]                     col_reg;
    logic [2:0]                     dcb_reg;
    logic [lcdni_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [lcdni_pkg::PRESC_W-1:0]  presc_reg, presc_next;
    logic [lcdni_pkg::US_W-1:0]     us_reg, us_next;
    logic                           m_tvalid_reg;
    logic [lcdni_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           m_tlast_reg;

    logic [lcdni_pkg::US_W-1:0] us_target;
    logic                       done;
    logic [7:0]                 cur_byte;
    logic [3:0]                 cur_nib;
    logic [5:0]                 before_ms;
    logic [2:0]                 after_ms;
    logic                       nib_last;
    logic                       slow_cmd;

    assign us_target = {strobe_reg, 1'b0};
    assign done      = us_reg >= us_target;

    always_comb begin
        presc_next = presc_reg;
        us_next    = us_reg;
        if (cmd.start) begin
            presc_next = '0;
            us_next    = '0;
        end else if (!done) begin
            if (presc_reg == lcdni_pkg::PRESC_W'(lcdni_pkg::CLK_PER_US - 1)) begin
                presc_next = '0;
                us_next    = us_reg + 1'b1;
            end else begin
                presc_next = presc_reg + 1'b1;
            end
        end
    end

    always_comb begin
        slow_cmd = 1'b0;
        unique case (op_reg)
            lcdni_pkg::OP_DATA, lcdni_pkg::OP_CMD: cur_byte = bv_reg;
            lcdni_pkg::OP_CURSOR: begin
                if (row_reg == 2'd0) begin
                    cur_byte = lcdni_pkg::CMD_ROW0 | {2'b00, col_reg};
                end else if (row_reg == 2'd1) begin
                    cur_byte = lcdni_pkg::CMD_ROW1 | {2'b00, col_reg};
                end else begin
                    cur_byte = {2'b00, col_reg};
                end
            end
            lcdni_pkg::OP_CLEAR: begin
                cur_byte = lcdni_pkg::CMD_CLEAR;
                slow_cmd = 1'b1;
            end
            lcdni_pkg::OP_HOME: begin
                cur_byte = lcdni_pkg::CMD_HOME;
                slow_cmd = 1'b1;
            end
            lcdni_pkg::OP_DISPLAY: begin
                cur_byte = lcdni_pkg::CMD_DISPLAY | {5'b00000, dcb_reg};
                slow_cmd = 1'b1;
            end
            lcdni_pkg::OP_INIT: cur_byte = lcdni_pkg::init_cmd(idx_reg[4:1]);
            default:            cur_byte = 8'h00;
        endcase
    end

    always_comb begin
        cur_nib   = idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
        before_ms = '0;
        after_ms  = '0;
        if (op_reg == lcdni_pkg::OP_INIT) begin
            nib_last = idx_reg == lcdni_pkg::INIT_LAST_IDX;
            if (idx_reg == '0) begin
                before_ms = lcdni_pkg::PAUSE_POWER_UP_MS;
            end
            if (idx_reg[0]) begin
                after_ms = (idx_reg[4:1] == 4'd0) ? lcdni_pkg::PAUSE_FIRST_MS
                                                  : lcdni_pkg::PAUSE_INIT_MS;
            end
        end else begin
            nib_last = idx_reg == lcdni_pkg::BYTE_LAST_IDX;
            if (idx_reg[0] && slow_cmd) begin
                after_ms = lcdni_pkg::PAUSE_SLOW_MS;
            end
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.load) begin
            idx_next = '0;
        end else if (cmd.emit) begin
            idx_next = nib_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strobe_reg   <= lcdni_pkg::STROBE_RESET;
            idx_reg      <= '0;
            presc_reg    <= '0;
            us_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                strobe_reg <= cfg_wdata;
            end
            idx_reg   <= idx_next;
            presc_reg <= presc_next;
            us_reg    <= us_next;
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_tuser;
            bv_reg  <= s_tdata[7:0];
            row_reg <= s_tdata[9:8];
            col_reg <= s_tdata[15:10];
            dcb_reg <= {s_tdata[16], s_tdata[17], s_tdata[18]};
        end
        if (cmd.emit) begin
            m_tdata_reg <= {3'b000, after_ms, before_ms, cur_nib};
            m_tuser_reg <= op_reg == lcdni_pkg::OP_DATA;
            m_tlast_reg <= nib_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign sts.op_known   = s_tuser <= lcdni_pkg::OP_INIT;
    assign sts.timer_done = done;
    assign sts.out_free   = !m_tvalid_reg || m_tready;
    assign sts.nib_last   = nib_last;

`ifndef SYNTH
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= lcdni_pkg::INIT_LAST_IDX)
        else $error("nibble index out of range");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("emitted nibble not presented");
    a_timer_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && !cmd.start) |=> $stable(us_reg))
        else $error("strobe timer ran past its target");
`endif

endmodule

[rtl/lcdni_ctrl.sv]
module lcdni_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lcdni_pkg::dp_sts_t   sts,
    output lcdni_pkg::ctrl_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   accept;

    assign accept    = s_tvalid && ready_reg;
    assign s_tready  = ready_reg;

    always_comb begin
        cmd.load  = 1'b0;
        cmd.start = 1'b0;
        cmd.emit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load  = accept;
                cmd.start = accept;
            end
            ST_RUN: begin
                cmd.emit  = sts.timer_done && sts.out_free;
                cmd.start = cmd.emit && !sts.nib_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && sts.op_known) begin
                        state_reg <= ST_RUN;
                        ready_reg <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (cmd.emit && sts.nib_last) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("nibble emitted over a waiting transaction");
    a_ready_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> !ready_reg)
        else $error("ready raised during a run");
    a_last_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && sts.nib_last) |=> ready_reg)
        else $error("ready not restored after final nibble");
`endif

endmodule
